FILE: rtl/two_pkg.sv
// Package with shared types and constants for the three-wheel odometry core.
`timescale 1ns / 1ps
package two_pkg;
    localparam logic [1:0] CFG_DIAMETER   = 2'd0;
    localparam logic [1:0] CFG_LEFT_OFF   = 2'd1;
    localparam logic [1:0] CFG_RIGHT_OFF  = 2'd2;
    localparam logic [1:0] CFG_HORIZ_OFF  = 2'd3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam logic signed [64:0] PI_Q32      = 65'sd13493037705;
    localparam logic signed [64:0] TWO_PI_Q32  = 65'sd26986075409;
    localparam logic signed [64:0] HALF_PI_Q32 = 65'sd6746518852;
    localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
    localparam logic [31:0] PI_Q30             = 32'd3373259426;
    // Largest shift of two pi tried when reducing a CORDIC angle; angles up to 2^39 fit.
    localparam int CORDIC_MOD_TOP = 4;

    typedef struct packed {
        logic        operation;
        logic [31:0] left_position;
        logic [31:0] right_position;
        logic [31:0] horizontal_position;
    } t_tick;

    typedef struct packed {
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [31:0] heading;
        logic        saturated;
    } t_pose;

    // Arctangent of 2^-i in 2^-32 rad, rounded.
    function automatic logic [33:0] atan_pow2(input logic [5:0] i);
        logic [33:0] v;
        case (i)
            6'd0:  v = 34'd3373259426;
            6'd1:  v = 34'd1991351318;
            6'd2:  v = 34'd1052175346;
            6'd3:  v = 34'd534100635;
            6'd4:  v = 34'd268086748;
            6'd5:  v = 34'd134174063;
            6'd6:  v = 34'd67103403;
            6'd7:  v = 34'd33553749;
            6'd8:  v = 34'd16777131;
            6'd9:  v = 34'd8388597;
            6'd10: v = 34'd4194303;
            6'd11: v = 34'd2097152;
            6'd12: v = 34'd1048576;
            default: v = 34'(64'd4294967296 >> i);
        endcase
        return v;
    endfunction
endpackage

FILE: rtl/two_stream_if.sv
// Valid/ready channel carrying one request of a given payload width.
`timescale 1ns / 1ps
interface two_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/three_wheel_odometry_core.sv
// Top level of the three-wheel tracking odometry core.
// Each tick request, from its acceptance to its result, runs through a sequencer that
// hands the work to a bit-serial 64x64 multiplier, a bit-serial divider and a CORDIC,
// one operation after another, and holds while each one runs. The CORDIC reduces the
// angle modulo two pi, folds it into range, then runs CORDIC_STEPS (24) micro-rotations.
// A tick with no heading change needs six products, two quotients and one rotation;
// one with a change needs ten products, three quotients and two rotations. The result
// of a reset request is offered the cycle after it is accepted. One request is worked
// on at a time; the result waits in an output register and no new request is taken
// until it has been accepted.
`timescale 1ns / 1ps
module three_wheel_odometry_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [two_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [two_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    two_stream_if.sink                         tick,
    two_stream_if.source                       pose
);
    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_SCALE = 17'b00000000000000010,
        S_SDIV  = 17'b00000000000000100,
        S_RT    = 17'b00000000000001000,
        S_HT    = 17'b00000000000010000,
        S_CNT   = 17'b00000000000100000,
        S_HDIV  = 17'b00000000001000000,
        S_CHK   = 17'b00000000010000000,
        S_SIN   = 17'b00000000100000000,
        S_CDIV  = 17'b00000001000000000,
        S_M1    = 17'b00000010000000000,
        S_M2    = 17'b00000100000000000,
        S_M3    = 17'b00001000000000000,
        S_M4    = 17'b00010000000000000,
        S_ROT   = 17'b00100000000000000,
        S_GX    = 17'b01000000000000000,
        S_GY    = 17'b10000000000000000
    } t_state;

    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
    localparam logic [63:0] PI_Q30_EXT = 64'(two_pkg::PI_Q30);

    t_state             r_state;
    logic               r_out_valid;
    two_pkg::t_pose     r_out;
    two_pkg::t_tick     r_in;
    two_pkg::t_tick     w_tick;
    logic [13:0]        r_diam;
    logic signed [15:0] r_loff;
    logic signed [15:0] r_roff;
    logic signed [15:0] r_hoff;
    logic signed [31:0] r_last_r;
    logic signed [31:0] r_last_h;
    logic signed [31:0] r_base_l;
    logic signed [31:0] r_base_r;
    logic signed [31:0] r_gx_acc;
    logic signed [31:0] r_gy_acc;
    logic signed [31:0] r_last_head;
    logic signed [63:0] r_s;
    logic signed [63:0] r_rt;
    logic signed [63:0] r_ht;
    logic signed [63:0] r_head;
    logic signed [63:0] r_dt;
    logic signed [63:0] r_s2;
    logic signed [63:0] r_c;
    logic signed [63:0] r_lx;
    logic signed [63:0] r_ly;
    logic signed [63:0] r_gx;
    logic               r_sat;
    logic               r_wait;

    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic               mul_done;
    logic signed [127:0] mul_p;
    logic               div_start;
    logic signed [63:0] div_num;
    logic signed [63:0] div_den;
    logic               div_done;
    logic signed [63:0] div_q;
    logic               cor_start;
    logic signed [63:0] cor_x;
    logic signed [63:0] cor_y;
    logic signed [64:0] cor_z;
    logic               cor_done;
    logic signed [63:0] cor_ox;
    logic signed [63:0] cor_oy;

    logic signed [63:0] w_w;
    logic signed [63:0] w_r20;
    logic signed [63:0] w_r30;

    two_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_p(mul_p)
    );
    two_serial_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_q(div_q)
    );
    two_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_x(cor_x), .i_y(cor_y),
        .i_z(cor_z), .o_done(cor_done), .o_x(cor_ox), .o_y(cor_oy)
    );

    assign w_tick = tick.data;
    assign w_w   = 64'(r_loff) + 64'(r_roff);
    // Rounded shifts of the last product, floor of (p + half) over the power.
    assign w_r20 = 64'((mul_p + 128'sd524288) >>> 20);
    assign w_r30 = 64'((mul_p + 128'sd536870912) >>> 30);

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
        return (v > I32_MAX) ? I32_MAX : ((v < I32_MIN) ? I32_MIN : v);
    endfunction

    function automatic logic over(input logic signed [63:0] v);
        return (v > I32_MAX) || (v < I32_MIN);
    endfunction

    assign tick.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign pose.valid  = r_out_valid;
    assign pose.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam <= 14'd2816;
            r_loff <= 16'sd7168;
            r_roff <= 16'sd7168;
            r_hoff <= 16'sd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                two_pkg::CFG_DIAMETER:  r_diam <= i_cfg_data[13:0];
                two_pkg::CFG_LEFT_OFF:  r_loff <= i_cfg_data;
                two_pkg::CFG_RIGHT_OFF: r_roff <= i_cfg_data;
                two_pkg::CFG_HORIZ_OFF: r_hoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            mul_start   <= 1'b0;
            div_start   <= 1'b0;
            cor_start   <= 1'b0;
            r_last_r    <= '0;
            r_last_h    <= '0;
            r_base_l    <= '0;
            r_base_r    <= '0;
            r_gx_acc    <= '0;
            r_gy_acc    <= '0;
            r_last_head <= '0;
        end else begin
            mul_start <= 1'b0;
            div_start <= 1'b0;
            cor_start <= 1'b0;
            if (pose.valid && pose.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tick.valid && tick.ready) begin
                        r_in  <= w_tick;
                        r_sat <= 1'b0;
                        if (w_tick.operation) begin
                            r_gx_acc    <= '0;
                            r_gy_acc    <= '0;
                            r_last_head <= '0;
                            r_base_l    <= w_tick.left_position;
                            r_base_r    <= w_tick.right_position;
                            r_last_r    <= w_tick.right_position;
                            r_last_h    <= w_tick.horizontal_position;
                            r_out       <= '0;
                            r_out_valid <= 1'b1;
                        end else begin
                            mul_a     <= 64'(r_diam);
                            mul_b     <= 64'(PI_Q30_EXT);
                            mul_start <= 1'b1;
                            r_state   <= S_SCALE;
                        end
                    end
                end
                S_SCALE: if (mul_done) begin
                    div_num   <= 64'(mul_p) + 64'sd288000;
                    div_den   <= 64'sd576000;
                    div_start <= 1'b1;
                    r_state   <= S_SDIV;
                end
                S_SDIV: if (div_done) begin
                    r_s       <= div_q;
                    mul_a     <= 64'($signed(r_in.right_position)) - 64'(r_last_r);
                    mul_b     <= div_q;
                    mul_start <= 1'b1;
                    r_state   <= S_RT;
                end
                S_RT: if (mul_done) begin
                    r_rt      <= clamp(w_r20);
                    r_sat     <= r_sat | over(w_r20);
                    mul_a     <= 64'($signed(r_in.horizontal_position)) - 64'(r_last_h);
                    mul_b     <= r_s;
                    mul_start <= 1'b1;
                    r_state   <= S_HT;
                end
                S_HT: if (mul_done) begin
                    r_ht      <= clamp(w_r20);
                    r_sat     <= r_sat | over(w_r20);
                    mul_a     <= (64'($signed(r_in.right_position)) - 64'(r_base_r))
                               - (64'($signed(r_in.left_position)) - 64'(r_base_l));
                    mul_b     <= r_s;
                    mul_start <= 1'b1;
                    r_state   <= S_CNT;
                end
                S_CNT: if (mul_done) begin
                    div_num   <= w_r20 <<< 18;
                    div_den   <= (w_w == 64'sd0) ? 64'sd1 : w_w;
                    r_wait    <= (w_w == 64'sd0);
                    div_start <= 1'b1;
                    r_state   <= S_HDIV;
                end
                S_HDIV: if (div_done) begin
                    r_head  <= clamp(r_wait ? 64'sd0 : div_q);
                    r_sat   <= r_sat | (!r_wait && over(div_q));
                    r_dt    <= clamp(r_wait ? 64'sd0 : div_q) - 64'(r_last_head);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_dt == 64'sd0) begin
                        r_lx      <= r_ht;
                        r_ly      <= r_rt;
                        cor_x     <= r_ht;
                        cor_y     <= r_rt;
                        cor_z     <= -(65'(r_last_head) <<< 8);
                        cor_start <= 1'b1;
                        r_state   <= S_ROT;
                    end else begin
                        cor_x     <= two_pkg::GAIN_Q30;
                        cor_y     <= '0;
                        cor_z     <= 65'(r_dt) <<< 7;
                        cor_start <= 1'b1;
                        r_state   <= S_SIN;
                    end
                end
                S_SIN: if (cor_done) begin
                    r_s2      <= cor_oy <<< 1;
                    div_num   <= cor_oy <<< 25;
                    div_den   <= r_dt;
                    div_start <= 1'b1;
                    r_state   <= S_CDIV;
                end
                S_CDIV: if (div_done) begin
                    r_c       <= (div_q > 64'sd2147483648) ? 64'sd2147483648 :
                                 ((div_q < -64'sd2147483648) ? -64'sd2147483648 : div_q);
                    mul_a     <= r_ht;
                    mul_b     <= (div_q > 64'sd2147483648) ? 64'sd2147483648 :
                                 ((div_q < -64'sd2147483648) ? -64'sd2147483648 : div_q);
                    mul_start <= 1'b1;
                    r_state   <= S_M1;
                end
                S_M1: if (mul_done) begin
                    r_lx      <= w_r30;
                    mul_a     <= 64'(r_hoff) <<< 6;
                    mul_b     <= r_s2;
                    mul_start <= 1'b1;
                    r_state   <= S_M2;
                end
                S_M2: if (mul_done) begin
                    r_lx      <= r_lx + w_r30;
                    mul_a     <= r_rt;
                    mul_b     <= r_c;
                    mul_start <= 1'b1;
                    r_state   <= S_M3;
                end
                S_M3: if (mul_done) begin
                    r_ly      <= w_r30;
                    mul_a     <= 64'(r_roff) <<< 6;
                    mul_b     <= r_s2;
                    mul_start <= 1'b1;
                    r_state   <= S_M4;
                end
                S_M4: if (mul_done) begin
                    r_lx      <= clamp(r_lx);
                    r_ly      <= clamp(r_ly + w_r30);
                    r_sat     <= r_sat | over(r_lx) | over(r_ly + w_r30);
                    cor_x     <= clamp(r_lx);
                    cor_y     <= clamp(r_ly + w_r30);
                    cor_z     <= -((65'(r_last_head) <<< 8) + (65'(r_dt) <<< 7));
                    cor_start <= 1'b1;
                    r_state   <= S_ROT;
                end
                S_ROT: if (cor_done) begin
                    r_ly      <= cor_oy;
                    mul_a     <= cor_ox;
                    mul_b     <= two_pkg::GAIN_Q30;
                    mul_start <= 1'b1;
                    r_state   <= S_GX;
                end
                S_GX: if (mul_done) begin
                    r_gx      <= w_r30;
                    mul_a     <= r_ly;
                    mul_b     <= two_pkg::GAIN_Q30;
                    mul_start <= 1'b1;
                    r_state   <= S_GY;
                end
                S_GY: if (mul_done) begin
                    r_gx_acc    <= 32'(clamp(64'(r_gx_acc) + r_gx));
                    r_gy_acc    <= 32'(clamp(64'(r_gy_acc) + w_r30));
                    r_last_head <= 32'(r_head);
                    r_last_r    <= r_in.right_position;
                    r_last_h    <= r_in.horizontal_position;
                    r_out.pose_x    <= 32'(clamp(64'(r_gx_acc) + r_gx));
                    r_out.pose_y    <= 32'(clamp(64'(r_gy_acc) + w_r30));
                    r_out.heading   <= 32'(r_head);
                    r_out.saturated <= r_sat | over(64'(r_gx_acc) + r_gx)
                                     | over(64'(r_gy_acc) + w_r30);
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/two_serial_mul.sv
// Shift-and-add signed multiplier that takes one bit of the multiplier a cycle.
`timescale 1ns / 1ps
module two_serial_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [127:0] o_p
);
    logic [6:0]          r_cnt;
    logic                r_busy;
    logic [63:0]         r_b;
    logic signed [127:0] r_acc;
    logic signed [127:0] r_a;
    logic signed [127:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (r_b[0]) begin
            // The top multiplier bit carries negative weight.
            n_acc = (r_cnt == 7'd63) ? r_acc - r_a : r_acc + r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= 128'(i_a);
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_p = n_acc;
endmodule

FILE: rtl/two_serial_div.sv
// Restoring divider giving one quotient bit a cycle, truncating toward zero.
`timescale 1ns / 1ps
module two_serial_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_q
);
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic [63:0] r_n;
    logic [63:0] r_d;
    logic [64:0] r_rem;
    logic [64:0] w_trial;
    logic [64:0] w_sub;

    assign w_trial = {r_rem[63:0], r_n[63]};
    assign w_sub   = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_neg  <= i_num[63] ^ i_den[63];
                r_n    <= i_num[63] ? 64'(-i_num) : 64'(i_num);
                r_d    <= i_den[63] ? 64'(-i_den) : 64'(i_den);
            end else if (r_busy) begin
                if (!w_sub[64]) begin
                    r_rem <= w_sub;
                    r_n   <= {r_n[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_n   <= {r_n[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_q = r_neg ? -$signed(r_n) : $signed(r_n);
endmodule

FILE: rtl/two_cordic.sv
// Rotation-mode CORDIC, one micro-rotation a cycle, with range reduction.
`timescale 1ns / 1ps
module two_cordic #(
    parameter int STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [64:0] i_z,
    output logic               o_done,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_RED  = 4'b0100,
        S_ROT  = 4'b1000
    } t_state;

    t_state              r_state;
    logic [5:0]          r_i;
    logic [2:0]          r_k;
    logic                r_neg;
    logic signed [63:0]  r_x;
    logic signed [63:0]  r_y;
    logic signed [64:0]  r_z;
    logic signed [64:0]  r_mag;
    logic signed [64:0]  w_step;
    logic signed [64:0]  w_mag;
    logic signed [64:0]  w_w;

    // The magnitude of z loses two pi times 2^k where it can, k counting down to zero,
    // which leaves the remainder of z over two pi with the sign of z, as in C.
    assign w_step = two_pkg::TWO_PI_Q32 <<< r_k;
    assign w_mag  = (r_mag >= w_step) ? r_mag - w_step : r_mag;

    always_comb begin
        w_w = r_z;
        if (r_z > two_pkg::PI_Q32) begin
            w_w = r_z - two_pkg::TWO_PI_Q32;
        end else if (r_z < -two_pkg::PI_Q32) begin
            w_w = r_z + two_pkg::TWO_PI_Q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_y     <= i_y;
                        r_neg   <= i_z[64];
                        r_mag   <= i_z[64] ? -i_z : i_z;
                        r_k     <= 3'(two_pkg::CORDIC_MOD_TOP);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_mag <= w_mag;
                    r_k   <= r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        r_z     <= r_neg ? -w_mag : w_mag;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_i     <= '0;
                    r_state <= S_ROT;
                    if (w_w > two_pkg::HALF_PI_Q32) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_z <= w_w - two_pkg::PI_Q32;
                    end else if (w_w < -two_pkg::HALF_PI_Q32) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_z <= w_w + two_pkg::PI_Q32;
                    end else begin
                        r_z <= w_w;
                    end
                end
                S_ROT: begin
                    if (!r_z[64]) begin
                        r_x <= r_x - (r_y >>> r_i);
                        r_y <= r_y + (r_x >>> r_i);
                        r_z <= r_z - 65'(two_pkg::atan_pow2(r_i));
                    end else begin
                        r_x <= r_x + (r_y >>> r_i);
                        r_y <= r_y - (r_x >>> r_i);
                        r_z <= r_z + 65'(two_pkg::atan_pow2(r_i));
                    end
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'(STEPS - 1)) begin
                        r_state <= S_IDLE;
                        o_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_x = r_x;
    assign o_y = r_y;
endmodule
